// ===== hw/rtl/plil_pkg.sv =====
// Shared types and constants for the positional list block.
package plil_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 2;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam int GRP_SIZE  = 8;
   localparam int GRP_SEL_W = 3;
   localparam int GRP_N     = 16;
   localparam int GRP_IDX_W = 4;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   localparam logic [DATA_W-1:0] NO_VALUE = '1;

   typedef struct packed {
      logic             ins;
      logic             del;
      logic [POS_W-1:0] slot;
   } plil_ctrl_type;

endpackage

// ===== hw/rtl/plil_cell.sv =====
// One list entry: takes its neighbor's value on a shift or the new value on an insert.
module plil_cell #(
   parameter int IDX   = 0,
   parameter int CMP_W = 8
) (
   input  logic                          clock,
   input  plil_pkg::plil_ctrl_type       ctrl,
   input  logic [plil_pkg::DATA_W-1:0]   new_value,
   input  logic [plil_pkg::DATA_W-1:0]   left_value,
   input  logic [plil_pkg::DATA_W-1:0]   right_value,
   output logic [plil_pkg::DATA_W-1:0]   value_q
);

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

   logic [plil_pkg::DATA_W-1:0] value_ff;
   logic [plil_pkg::DATA_W-1:0] value_in;
   logic [CMP_W-1:0]            slot_ext;
   logic                        load;

   assign slot_ext = CMP_W'(ctrl.slot);

   always_comb begin
      value_in = value_ff;
      load     = 1'b0;
      if (ctrl.ins) begin
         if (MY_IDX == slot_ext) begin
            value_in = new_value;
            load     = 1'b1;
         end else if (MY_IDX > slot_ext) begin
            value_in = left_value;
            load     = 1'b1;
         end
      end else if (ctrl.del) begin
         if (MY_IDX >= slot_ext) begin
            value_in = right_value;
            load     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
      end
   end

   assign value_q = value_ff;

endmodule

// ===== hw/rtl/plil_read_sel.sv =====
// Two-level read select of the entry being deleted: group pick registered, then final pick.
module plil_read_sel #(
   parameter int CAPACITY = plil_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          capture,
   input  logic [plil_pkg::POS_W-1:0]    slot,
   input  logic [plil_pkg::DATA_W-1:0]   cell_q [CAPACITY],
   output logic [plil_pkg::DATA_W-1:0]   rd_value
);

   logic [plil_pkg::DATA_W-1:0]  cand [plil_pkg::GRP_N][plil_pkg::GRP_SIZE];
   logic [plil_pkg::DATA_W-1:0]  grp_in [plil_pkg::GRP_N];
   logic [plil_pkg::DATA_W-1:0]  grp_ff [plil_pkg::GRP_N];
   logic [plil_pkg::GRP_IDX_W-1:0] grp_idx_ff;
   logic [plil_pkg::GRP_SEL_W-1:0] sel_lo;

   assign sel_lo = slot[plil_pkg::GRP_SEL_W-1:0];

   for (genvar g = 0; g < plil_pkg::GRP_N; g++) begin : g_grp
      for (genvar k = 0; k < plil_pkg::GRP_SIZE; k++) begin : g_mem
         if (g * plil_pkg::GRP_SIZE + k < CAPACITY) begin : g_real
            assign cand[g][k] = cell_q[g * plil_pkg::GRP_SIZE + k];
         end else begin : g_pad
            assign cand[g][k] = '0;
         end
      end
      assign grp_in[g] = cand[g][sel_lo];
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         grp_ff     <= grp_in;
         grp_idx_ff <= slot[plil_pkg::POS_W-1:plil_pkg::GRP_SEL_W];
      end
   end

   assign rd_value = grp_ff[grp_idx_ff];

endmodule

// ===== hw/rtl/positional_list_insert_delete.sv =====
// Top level of the positional list: request/response streams around a chain of entry cells.
//
// Ordered list of up to CAPACITY signed 32-bit values held one per cell.
// req channel: tuser = mode (0 insert, 1 delete); tdata = position, value.
// Insert places value at 0-based slot 0..count, later entries move back one
// cell. Delete removes 1-based entry 1..count and returns it, later entries
// move forward one cell. Every request yields one rsp transfer carrying the
// removed value (-1 when nothing was removed), status (0 done, 1 position
// out of range, 2 list full) and the entry count after the operation.
// Steps: a request is taken in S_IDLE; in S_EXEC all cells shift and the
// group pick of the two-level select (group of eight, then group) is
// registered from the cells as they were before the shift; in S_FIN the
// final pick gives the deleted entry and the rsp register is loaded once
// it is free, and a new req is taken only after that.
// A result held in the rsp register while rsp_tready is low does not stop
// the next request; only a second finished result waits for the register.
// Reset empties the list (count zero) and drops any pending response.
module positional_list_insert_delete #(
   parameter int CAPACITY = plil_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [plil_pkg::REQ_TDATA_W-1:0]      req_tdata,  // position[6:0], value[38:7], zero
   input  logic                                  req_tuser,  // mode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [plil_pkg::RSP_TDATA_W-1:0]      rsp_tdata   // removed_value[31:0], status[33:32],
                                                             // entry_count[40:34], zero
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > plil_pkg::POS_W) ? CNT_W : plil_pkg::POS_W;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              mode_ff;
   logic [plil_pkg::POS_W-1:0]        pos_ff;
   logic [plil_pkg::DATA_W-1:0]       val_ff;
   logic [plil_pkg::STAT_W-1:0]       status_ff, status_in;
   logic                              del_ok_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [plil_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   plil_pkg::plil_ctrl_type           ctrl;
   logic [CMP_W-1:0]                  pos_ext, cnt_ext, cnt_out_ext;
   logic                              req_fire, out_load;
   logic [plil_pkg::DATA_W-1:0]       cell_q [CAPACITY];
   logic [plil_pkg::DATA_W-1:0]       rd_value;
   logic [plil_pkg::DATA_W-1:0]       removed;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);

   always_comb begin
      ctrl      = '0;
      status_in = plil_pkg::ST_DONE;
      count_in  = count_ff;
      ctrl.slot = pos_ff;
      if (mode_ff == plil_pkg::MODE_INSERT) begin
         if (pos_ext > cnt_ext) begin
            status_in = plil_pkg::ST_RANGE;
         end else if (cnt_ext >= CAP_C) begin
            status_in = plil_pkg::ST_FULL;
         end else begin
            ctrl.ins = (state_ff == S_EXEC);
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         ctrl.slot = pos_ff - plil_pkg::POS_W'(1);
         if ((pos_ff == '0) || (pos_ext > cnt_ext)) begin
            status_in = plil_pkg::ST_RANGE;
         end else begin
            ctrl.del = (state_ff == S_EXEC);
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) state_in = S_EXEC;
         S_EXEC: state_in = S_FIN;
         S_FIN:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign cnt_out_ext = CMP_W'(count_ff);
   assign removed     = del_ok_ff ? rd_value : plil_pkg::NO_VALUE;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, cnt_out_ext[plil_pkg::POS_W-1:0], status_ff, removed};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXEC) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_tuser;
         pos_ff  <= req_tdata[plil_pkg::POS_W-1:0];
         val_ff  <= req_tdata[plil_pkg::POS_W+plil_pkg::DATA_W-1:plil_pkg::POS_W];
      end
      if (state_ff == S_EXEC) begin
         status_ff <= status_in;
         del_ok_ff <= ctrl.del;
      end
      rsp_data_ff <= rsp_data_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [plil_pkg::DATA_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = val_ff;
      end else begin : g_left
         assign left_v = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_q[i];
      end else begin : g_right
         assign right_v = cell_q[i+1];
      end
      plil_cell #(
         .IDX   (i),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (val_ff),
         .left_value  (left_v),
         .right_value (right_v),
         .value_q     (cell_q[i])
      );
   end

   plil_read_sel #(
      .CAPACITY (CAPACITY)
   ) u_read_sel (
      .clock    (clock),
      .capture  (state_ff == S_EXEC),
      .slot     (ctrl.slot),
      .cell_q   (cell_q),
      .rd_value (rd_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ext <= CAP_C)
      else $error("entry count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted request did not start execution");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("response raised outside finish step");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> $stable(count_ff))
      else $error("entry count changed outside execution");

   a_cells_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |-> !(ctrl.ins || ctrl.del))
      else $error("cell shift outside execution");

endmodule

// ===== sim/list_checker.sv =====
// Checker for the positional list: predicts each response and compares it with the stream.
`timescale 1ns / 100ps

module list_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [plil_pkg::REQ_TDATA_W-1:0] req_tdata,  // position[6:0], value[38:7], zero
   input  logic                             req_tuser,  // mode
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [plil_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // removed_value[31:0], status[33:32],
                                                        // entry_count[40:34], zero
   output int                               pending,
   output int                               fail_count,
   output int                               checked
);

   typedef struct packed {
      logic [plil_pkg::DATA_W-1:0] removed;
      logic [plil_pkg::STAT_W-1:0] status;
      logic [plil_pkg::POS_W-1:0]  count;
   } list_result_type;

   logic [plil_pkg::DATA_W-1:0] slots [plil_pkg::CAPACITY_DEF];
   int                          fill;
   list_result_type             expected_q[$];
   int                          errs;
   int                          n_checked;

   function automatic list_result_type apply_request(input logic mode,
                                                     input logic [plil_pkg::POS_W-1:0] pos,
                                                     input logic [plil_pkg::DATA_W-1:0] val);
      list_result_type r;
      int              i;
      r.removed = plil_pkg::NO_VALUE;
      r.status  = plil_pkg::ST_DONE;
      if (mode == plil_pkg::MODE_INSERT) begin
         if (pos > fill) begin
            r.status = plil_pkg::ST_RANGE;
         end else if (fill >= plil_pkg::CAPACITY_DEF) begin
            r.status = plil_pkg::ST_FULL;
         end else begin
            for (i = fill; i > int'(pos); i--) slots[i] = slots[i-1];
            slots[pos] = val;
            fill++;
         end
      end else if (pos == 0 || pos > fill) begin
         r.status = plil_pkg::ST_RANGE;
      end else begin
         r.removed = slots[pos-1];
         for (i = int'(pos) - 1; i + 1 < fill; i++) slots[i] = slots[i+1];
         fill--;
      end
      r.count = fill[plil_pkg::POS_W-1:0];
      return r;
   endfunction

   task automatic note_mismatch(input string field, input logic [plil_pkg::DATA_W-1:0] want,
                                input logic [plil_pkg::DATA_W-1:0] got);
      errs++;
      if (errs <= 10)
         $display("list_checker: %s mismatch at %0t: expected %h, got %h",
                  field, $realtime, want, got);
   endtask

   always @(posedge clock) begin : watch
      list_result_type got;
      list_result_type want;
      if (reset) begin
         expected_q.delete();
         fill = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.removed = rsp_tdata[31:0];
            got.status  = rsp_tdata[33:32];
            got.count   = rsp_tdata[40:34];
            if (expected_q.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("list_checker: unexpected transfer at %0t: %h",
                           $realtime, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               n_checked++;
               if (got.removed !== want.removed)
                  note_mismatch("removed_value", want.removed, got.removed);
               if (got.status !== want.status)
                  note_mismatch("status", plil_pkg::DATA_W'(want.status),
                                plil_pkg::DATA_W'(got.status));
               if (got.count !== want.count)
                  note_mismatch("entry_count", plil_pkg::DATA_W'(want.count),
                                plil_pkg::DATA_W'(got.count));
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(apply_request(req_tuser, req_tdata[6:0], req_tdata[38:7]));
      end
      pending    <= expected_q.size();
      fail_count <= errs;
      checked    <= n_checked;
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the positional list: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [plil_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;  // position[6:0], value[38:7], zero
   logic                             req_tuser  = 1'b0;  // mode
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [plil_pkg::RSP_TDATA_W-1:0] rsp_tdata;  // removed_value[31:0], status[33:32],
                                                 // entry_count[40:34], zero

   int pending;
   int fail_count;
   int checked;

   bit idle_en      = 1'b1;
   int holdoff_reqs = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int stall_left   = 0;

   int  list_cnt     = 0;
   int  n_sent       = 0;
   int  fills        = 0;
   int  empties      = 0;
   int  full_rejects = 0;
   bit  tide_down    = 1'b0;

   positional_list_insert_delete dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .pending    (pending),
      .fail_count (fail_count),
      .checked    (checked)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("tb_top: errors");
      $finish;
   end

   // response side: random stall bursts plus a single long hold-off
   always @(posedge clock) begin
      if (holdoff_seen != holdoff_reqs) begin
         holdoff_seen <= holdoff_reqs;
         holdoff_left <= 300;
         rsp_tready   <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_req(input logic mode, input logic [plil_pkg::POS_W-1:0] pos,
                           input logic [plil_pkg::DATA_W-1:0] val);
      int gap;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, val, pos};
      do @(posedge clock); while (!req_tready);
      n_sent++;
      if (mode == plil_pkg::MODE_INSERT) begin
         if (pos <= list_cnt) begin
            if (list_cnt == plil_pkg::CAPACITY_DEF) begin
               full_rejects++;
            end else begin
               list_cnt++;
               if (list_cnt == plil_pkg::CAPACITY_DEF) fills++;
            end
         end
      end else if (pos >= 1 && pos <= list_cnt) begin
         list_cnt--;
         if (list_cnt == 0) empties++;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [plil_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [plil_pkg::POS_W-1:0] pick_pos(input logic mode);
      if ($urandom_range(0, 9) == 0) return plil_pkg::POS_W'($urandom_range(0, 127));
      if (mode == plil_pkg::MODE_INSERT) return plil_pkg::POS_W'($urandom_range(0, list_cnt));
      return plil_pkg::POS_W'($urandom_range(1, list_cnt));
   endfunction

   initial begin : stimulus
      logic mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, rejections, head insert, stored minus one, extremes
      send_req(plil_pkg::MODE_DELETE, 7'd0, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd1, '0);
      send_req(plil_pkg::MODE_INSERT, 7'd1, 32'h1234_5678);
      send_req(plil_pkg::MODE_INSERT, 7'd127, '1);
      send_req(plil_pkg::MODE_INSERT, 7'd0, '1);
      send_req(plil_pkg::MODE_INSERT, 7'd1, 32'h7FFF_FFFF);
      send_req(plil_pkg::MODE_INSERT, 7'd0, 32'h8000_0000);
      send_req(plil_pkg::MODE_INSERT, 7'd2, '0);
      send_req(plil_pkg::MODE_INSERT, 7'd5, 32'hFFFF_0000);
      send_req(plil_pkg::MODE_DELETE, 7'd0, '1);
      send_req(plil_pkg::MODE_DELETE, 7'd5, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd2, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd3, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd1, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd64, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd1, '0);
      send_req(plil_pkg::MODE_INSERT, 7'd0, 32'h0000_0001);
      send_req(plil_pkg::MODE_INSERT, 7'd1, 32'hAAAA_AAAA);
      send_req(plil_pkg::MODE_INSERT, 7'd0, 32'h5555_5555);

      // fill to capacity, then full and range cases at the limit
      while (list_cnt < plil_pkg::CAPACITY_DEF)
         send_req(plil_pkg::MODE_INSERT, plil_pkg::POS_W'($urandom_range(0, list_cnt)),
                  $urandom());
      send_req(plil_pkg::MODE_INSERT, 7'd64, 32'h0BAD_F00D);
      send_req(plil_pkg::MODE_INSERT, 7'd0, '1);
      send_req(plil_pkg::MODE_INSERT, 7'd65, '0);
      send_req(plil_pkg::MODE_INSERT, 7'd127, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd64, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd64, '0);
      send_req(plil_pkg::MODE_DELETE, 7'd1, '0);
      wait_drained();
      tide_down = 1'b1;

      for (int i = 0; i < 1500; i++) begin
         idle_en = (i < 1200);
         if (i == 500) holdoff_reqs <= holdoff_reqs + 1;
         if (i % 400 == 399) wait_drained();
         if (list_cnt == plil_pkg::CAPACITY_DEF) tide_down = 1'b1;
         if (list_cnt == 0) tide_down = 1'b0;
         mode = tide_down ? plil_pkg::MODE_DELETE : plil_pkg::MODE_INSERT;
         if ($urandom_range(0, 3) == 0) mode = ~mode;
         send_req(mode, pick_pos(mode), pick_value());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("tb_top: %0d requests sent, %0d responses checked", n_sent, checked);
      $display("tb_top: list filled %0d times, emptied %0d times, %0d inserts refused as full",
               fills, empties, full_rejects);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/plil_pkg.sv
hw/rtl/plil_cell.sv
hw/rtl/plil_read_sel.sv
hw/rtl/positional_list_insert_delete.sv
sim/list_checker.sv
sim/tb_top.sv
